@@ design/bsob_pkg.sv @@
// shared types and constants for the buy side order book matcher
// used by the controller, the datapath and the top level
package bsob_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_MATCH  = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    RK_FILL       = 3'd0,
    RK_MATCH_DONE = 3'd1,
    RK_ADD_OK     = 3'd2,
    RK_ADD_FULL   = 3'd3,
    RK_CANCEL_OK  = 3'd4,
    RK_CANCEL_NF  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FILL,
    ST_OUT
  } state_e;

  localparam logic [31:0] EXEC_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] order_id;
    logic [31:0] limit_price;
    logic [31:0] order_count;
    logic [31:0] timestamp;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] resting_id;
    logic [31:0] incoming_id;
    logic [31:0] exec_number;
    logic [31:0] fill_price;
    logic [31:0] fill_count;
    logic [31:0] fill_time;
    logic [31:0] total_filled;
    logic        last_item;
  } res_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic do_add;
    logic do_fill;
    logic do_cancel;
    logic out_load;
    logic [2:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic has_free;
    logic want_zero;
    logic fill_limit;
    logic [1:0] req_type;
  } sts_t;

endpackage

@@ design/bsob_ctrl.sv @@
// controller state machine for the order book
// depends on bsob_pkg
module bsob_ctrl
  import bsob_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic out_full_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.req_type == REQ_NONE) state_d = ST_IDLE;
        else if (sts_i.scan_last) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_full_i) begin
          if (sts_i.req_type == REQ_MATCH && sts_i.found && !sts_i.want_zero &&
              !sts_i.fill_limit) state_d = ST_FILL;
          else state_d = ST_OUT;
        end
      end
      ST_FILL: state_d = ST_SCAN;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    cmd_o.out_kind = RK_FILL;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        cmd_o.scan_start = in_valid_i;
      end
      ST_SCAN: cmd_o.scan_step = 1'b1;
      ST_DECIDE: begin
        if (!out_full_i) begin
          cmd_o.out_load = 1'b1;
          unique case (sts_i.req_type)
            REQ_ADD: begin
              cmd_o.do_add = sts_i.has_free;
              cmd_o.out_kind = sts_i.has_free ? RK_ADD_OK : RK_ADD_FULL;
            end
            REQ_MATCH: begin
              if (sts_i.found && !sts_i.want_zero && !sts_i.fill_limit) begin
                cmd_o.do_fill = 1'b1;
                cmd_o.out_kind = RK_FILL;
              end else begin
                cmd_o.out_kind = RK_MATCH_DONE;
              end
            end
            REQ_CANCEL: begin
              cmd_o.do_cancel = sts_i.found;
              cmd_o.out_kind = sts_i.found ? RK_CANCEL_OK : RK_CANCEL_NF;
            end
            default: cmd_o.out_load = 1'b0;
          endcase
        end
      end
      ST_FILL: cmd_o.scan_start = 1'b1;
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule

@@ design/bsob_dp.sv @@
// datapath: slot table, serial best-order scan, result register
// depends on bsob_pkg
module bsob_dp
  import bsob_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  localparam int unsigned IW = $clog2(ORDER_SLOTS);
  localparam int unsigned CW = $clog2(ORDER_SLOTS + 1);

  logic [ORDER_SLOTS-1:0] vld_q;
  logic [31:0] id_q [ORDER_SLOTS];
  logic [31:0] pr_q [ORDER_SLOTS];
  logic [31:0] rem_q [ORDER_SLOTS];
  logic [31:0] ex_q [ORDER_SLOTS];
  logic [31:0] arr_q [ORDER_SLOTS];
  logic [31:0] arrcnt_q;

  req_t r_q;
  logic [IW-1:0] idx_q, best_q, free_q;
  logic found_q, free_ok_q;
  logic [31:0] bpr_q, bage_q;
  logic [31:0] left_q, tot_q;
  logic [CW-1:0] nfill_q;
  logic ov_q, ov_d;
  res_t res_q, res_d;

  logic [31:0] age_c, q_c;
  logic cand_c, better_c;

  assign age_c = arrcnt_q - arr_q[idx_q];
  assign cand_c = vld_q[idx_q] &&
                  ((r_q.req_type == REQ_MATCH && pr_q[idx_q] >= r_q.limit_price) ||
                   (r_q.req_type == REQ_CANCEL && id_q[idx_q] == r_q.order_id));
  always_comb begin
    if (!found_q) better_c = 1'b1;
    else if (pr_q[idx_q] == bpr_q) better_c = age_c > bage_q;
    else if (r_q.req_type == REQ_MATCH) better_c = pr_q[idx_q] > bpr_q;
    else better_c = pr_q[idx_q] < bpr_q;
  end
  assign q_c = (rem_q[best_q] < left_q) ? rem_q[best_q] : left_q;

  always_comb begin
    ov_d = ov_q;
    if (out_valid_o && !out_stall_i) ov_d = 1'b0;
    if (cmd_i.out_load) ov_d = 1'b1;
  end

  always_comb begin
    res_d = '0;
    res_d.result_kind = cmd_i.out_kind;
    res_d.incoming_id = r_q.order_id;
    if (cmd_i.do_fill) begin
      res_d.resting_id = id_q[best_q];
      res_d.exec_number = ex_q[best_q];
      res_d.fill_price = pr_q[best_q];
      res_d.fill_count = q_c;
      res_d.fill_time = r_q.timestamp;
    end else begin
      res_d.last_item = 1'b1;
      if (cmd_i.out_kind == RK_MATCH_DONE) res_d.total_filled = tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      arrcnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (cmd_i.do_add) begin
        vld_q[free_q] <= 1'b1;
        arrcnt_q <= arrcnt_q + 32'd1;
      end
      if (cmd_i.do_cancel) vld_q[best_q] <= 1'b0;
      if (cmd_i.do_fill && rem_q[best_q] == q_c) vld_q[best_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= req_i;
      left_q <= req_i.order_count;
      tot_q <= '0;
      nfill_q <= '0;
    end
    if (cmd_i.scan_start) begin
      idx_q <= '0;
      found_q <= 1'b0;
      free_ok_q <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      idx_q <= idx_q + IW'(1);
      if (cand_c && better_c) begin
        found_q <= 1'b1;
        best_q <= idx_q;
        bpr_q <= pr_q[idx_q];
        bage_q <= age_c;
      end
      if (!vld_q[idx_q] && !free_ok_q) begin
        free_ok_q <= 1'b1;
        free_q <= idx_q;
      end
    end
    if (cmd_i.do_add) begin
      id_q[free_q] <= r_q.order_id;
      pr_q[free_q] <= r_q.limit_price;
      rem_q[free_q] <= r_q.order_count;
      ex_q[free_q] <= 32'd1;
      arr_q[free_q] <= arrcnt_q;
    end
    if (cmd_i.do_fill) begin
      rem_q[best_q] <= rem_q[best_q] - q_c;
      if (ex_q[best_q] != EXEC_MAX) ex_q[best_q] <= ex_q[best_q] + 32'd1;
      left_q <= left_q - q_c;
      tot_q <= tot_q + q_c;
      nfill_q <= nfill_q + CW'(1);
    end
    if (cmd_i.out_load) res_q <= res_d;
  end

  assign sts_o.scan_last = (idx_q == IW'(ORDER_SLOTS - 1));
  assign sts_o.found = found_q;
  assign sts_o.has_free = free_ok_q;
  assign sts_o.want_zero = (left_q == '0);
  assign sts_o.fill_limit = (nfill_q == CW'(ORDER_SLOTS));
  assign sts_o.req_type = r_q.req_type;
  assign out_valid_o = ov_q;
  assign res_o = res_q;

endmodule

@@ design/buy_side_order_book_matcher_unit.sv @@
// top level of the buy side order book matcher
// an add or cancel stalls the input through the scan, decide and output states, so a new
// item is taken only when the block is idle again; its result is registered in the decide
// state and offered from the output state on; a match repeats the full slot scan for
// each fill, up to ORDER_SLOTS fills, and a stalled result holds the block in decide
// reset clears the valid marks and the arrival counter at once
module buy_side_order_book_matcher_unit
  import bsob_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  bsob_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_full_i(out_valid_o && out_stall_i), .sts_i(sts), .cmd_o(cmd)
  );

  bsob_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .res_o(out_data_o)
  );

`ifndef SYNTH
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.do_add, cmd.do_fill, cmd.do_cancel}) <= 1)
    else $error("more than one table update");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_step || cmd.do_fill) |-> in_stall_o)
    else $error("item taken while busy");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("result lost");
`endif

endmodule

@@ tb/bsob_checker.sv @@
// order book checker: predicts the result items of each accepted request
// and compares them with the results leaving the block; needs bsob_pkg only
`timescale 1ns / 100ps
module bsob_checker
  import bsob_pkg::*;
#(
  parameter int unsigned ORDER_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  req_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  res_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic        book_valid [ORDER_SLOTS];
  logic [31:0] book_id    [ORDER_SLOTS];
  logic [31:0] book_price [ORDER_SLOTS];
  logic [31:0] book_left  [ORDER_SLOTS];
  logic [31:0] book_exec  [ORDER_SLOTS];
  logic [31:0] book_arr   [ORDER_SLOTS];
  logic [31:0] arrivals;
  res_t        due_results [$];
  int unsigned fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = due_results.size();

  function automatic res_t make_result(kind_e kind, logic [31:0] rid, logic [31:0] iid,
                                       logic [31:0] ex, logic [31:0] pr, logic [31:0] cnt,
                                       logic [31:0] tm, logic [31:0] tot, logic last);
    res_t r;
    r.result_kind  = kind;
    r.resting_id   = rid;
    r.incoming_id  = iid;
    r.exec_number  = ex;
    r.fill_price   = pr;
    r.fill_count   = cnt;
    r.fill_time    = tm;
    r.total_filled = tot;
    r.last_item    = last;
    return r;
  endfunction

  task automatic add_due(res_t r);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic apply_request(req_t r);
    int          s;
    int          hit;
    int          n;
    logic [31:0] want;
    logic [31:0] total;
    logic [31:0] q;
    case (req_e'(r.req_type))
      REQ_ADD: begin
        hit = -1;
        for (s = 0; s < ORDER_SLOTS; s++) if (!book_valid[s] && hit < 0) hit = s;
        if (hit < 0) begin
          add_due(make_result(RK_ADD_FULL, 0, r.order_id, 0, 0, 0, 0, 0, 1'b1));
        end else begin
          book_valid[hit] = 1'b1;
          book_id[hit]    = r.order_id;
          book_price[hit] = r.limit_price;
          book_left[hit]  = r.order_count;
          book_exec[hit]  = 32'd1;
          book_arr[hit]   = arrivals;
          arrivals        = arrivals + 32'd1;
          add_due(make_result(RK_ADD_OK, 0, r.order_id, 0, 0, 0, 0, 0, 1'b1));
        end
      end
      REQ_MATCH: begin
        n     = 0;
        total = '0;
        want  = r.order_count;
        while (want != 0 && n < ORDER_SLOTS) begin
          hit = -1;
          for (s = 0; s < ORDER_SLOTS; s++) begin
            if (book_valid[s] && book_price[s] >= r.limit_price) begin
              if (hit < 0 || book_price[s] > book_price[hit] ||
                  (book_price[s] == book_price[hit] &&
                   (arrivals - book_arr[s]) > (arrivals - book_arr[hit])))
                hit = s;
            end
          end
          if (hit < 0) break;
          q = (book_left[hit] < want) ? book_left[hit] : want;
          book_left[hit] = book_left[hit] - q;
          want  = want - q;
          total = total + q;
          add_due(make_result(RK_FILL, book_id[hit], r.order_id, book_exec[hit],
                              book_price[hit], q, r.timestamp, 0, 1'b0));
          n++;
          if (book_exec[hit] != EXEC_MAX) book_exec[hit] = book_exec[hit] + 32'd1;
          if (book_left[hit] == 0) book_valid[hit] = 1'b0;
        end
        add_due(make_result(RK_MATCH_DONE, 0, r.order_id, 0, 0, 0, 0, total, 1'b1));
      end
      REQ_CANCEL: begin
        hit = -1;
        for (s = 0; s < ORDER_SLOTS; s++) begin
          if (book_valid[s] && book_id[s] == r.order_id) begin
            if (hit < 0 || book_price[s] < book_price[hit] ||
                (book_price[s] == book_price[hit] &&
                 (arrivals - book_arr[s]) > (arrivals - book_arr[hit])))
              hit = s;
          end
        end
        if (hit >= 0) begin
          book_valid[hit] = 1'b0;
          add_due(make_result(RK_CANCEL_OK, 0, r.order_id, 0, 0, 0, 0, 0, 1'b1));
        end else begin
          add_due(make_result(RK_CANCEL_NF, 0, r.order_id, 0, 0, 0, 0, 0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (due_results.size() == 0) begin
      report("unexpected result", got.incoming_id, 32'd0);
      return;
    end
    want = due_results.pop_front();
    if (got.result_kind !== want.result_kind)
      report("result_kind", 32'(got.result_kind), 32'(want.result_kind));
    if (got.resting_id !== want.resting_id) report("resting_id", got.resting_id, want.resting_id);
    if (got.incoming_id !== want.incoming_id)
      report("incoming_id", got.incoming_id, want.incoming_id);
    if (got.exec_number !== want.exec_number)
      report("exec_number", got.exec_number, want.exec_number);
    if (got.fill_price !== want.fill_price) report("fill_price", got.fill_price, want.fill_price);
    if (got.fill_count !== want.fill_count) report("fill_count", got.fill_count, want.fill_count);
    if (got.fill_time !== want.fill_time) report("fill_time", got.fill_time, want.fill_time);
    if (got.total_filled !== want.total_filled)
      report("total_filled", got.total_filled, want.total_filled);
    if (got.last_item !== want.last_item)
      report("last_item", 32'(got.last_item), 32'(want.last_item));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ORDER_SLOTS; s++) book_valid[s] = 1'b0;
      arrivals = '0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) apply_request(in_data_i);
    end
  end

endmodule

@@ tb/tb_buy_side_order_book_matcher_unit.sv @@
// testbench top: drives requests and result stalls into the order book matcher
// and gives the verdict; needs bsob_pkg, bsob_checker and the block
`timescale 1ns / 100ps
module tb_buy_side_order_book_matcher_unit;
  import bsob_pkg::*;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  req_t        in_data;
  logic        out_valid;
  logic        out_stall;
  res_t        out_data;
  int unsigned fail_count;
  int unsigned pending;
  logic        quiet;
  logic        hold_req;
  int unsigned idle_cycles = 0;

  buy_side_order_book_matcher_unit #(.ORDER_SLOTS(SLOTS)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  bsob_checker #(.ORDER_SLOTS(SLOTS)) u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t make_req(req_e kind, logic [31:0] id, logic [31:0] price,
                                    logic [31:0] cnt, logic [31:0] ts);
    req_t r;
    r.req_type    = kind;
    r.order_id    = id;
    r.limit_price = price;
    r.order_count = cnt;
    r.timestamp   = ts;
    return r;
  endfunction

  function automatic req_t random_req(int unsigned add_weight);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.timestamp = $urandom;
    r.order_id  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 12);
    case ($urandom_range(9))
      0:       r.limit_price = $urandom;
      1:       r.limit_price = 32'hFFFF_FFFF - $urandom_range(3);
      2:       r.limit_price = $urandom_range(3);
      default: r.limit_price = 32'd1000 + $urandom_range(7);
    endcase
    case ($urandom_range(9))
      0:       r.order_count = $urandom;
      1:       r.order_count = 0;
      default: r.order_count = $urandom_range(1, 40);
    endcase
    if (pick < 2) r.req_type = REQ_NONE;
    else if (pick < add_weight) r.req_type = REQ_ADD;
    else if (pick < add_weight + (100 - add_weight) * 2 / 3) r.req_type = REQ_MATCH;
    else r.req_type = REQ_CANCEL;
    return r;
  endfunction

  task automatic send(req_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int   sent;
    req_t r;
    in_valid    <= 1'b0;
    in_data     <= '0;
    quiet       <= 1'b0;
    hold_req    <= 1'b0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(make_req(REQ_MATCH, 32'h11, 0, 32'd5, 32'h1));
    send(make_req(REQ_CANCEL, 32'h22, 0, 0, 0));
    send(make_req(REQ_ADD, 32'h0, 32'h0, 32'h0, 32'h0));
    send(make_req(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_req(REQ_ADD, 32'h5, 32'd100, 32'd10, 0));
    send(make_req(REQ_ADD, 32'h5, 32'd50, 32'd10, 0));
    send(make_req(REQ_ADD, 32'h6, 32'd100, 32'd3, 0));
    send(make_req(REQ_NONE, 32'h7, 32'd100, 32'd3, 0));
    send(make_req(REQ_MATCH, 32'h30, 32'd10, 32'd0, 32'hA5A5_5A5A));
    send(make_req(REQ_CANCEL, 32'h5, 0, 0, 0));
    send(make_req(REQ_MATCH, 32'h31, 32'hFFFF_FFFF, 32'd7, 32'h5A5A_A5A5));
    send(make_req(REQ_MATCH, 32'h32, 32'd100, 32'd12, 32'h1234_5678));
    send(make_req(REQ_MATCH, 32'h33, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(make_req(REQ_CANCEL, 32'h5, 0, 0, 0));
    send(make_req(REQ_CANCEL, 32'hFFFF_FFFF, 0, 0, 0));

    // fill the book past capacity, then sweep it with one match
    for (int i = 0; i < SLOTS + 2; i++)
      send(make_req(REQ_ADD, 32'(i + 100), 32'd2000 + 32'(i % 3), 32'd1, 32'(i)));
    send(make_req(REQ_MATCH, 32'h40, 32'd1, 32'hFFFF_FFFF, 32'hCAFE_F00D));

    sent = 0;
    while (sent < 400) begin
      if (sent == 130) hold_req <= 1'b1;
      if (sent == 230) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      if (sent == 350) quiet <= 1'b1;
      r = random_req((sent < 80) ? 60 : 40);
      send(r);
      if (r.req_type != REQ_NONE) sent++;
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
